FILE: hdl/arp_pkg.sv
package arp_pkg;

  localparam int unsigned MaxRects   = 64;
  localparam int unsigned CoordBits  = 13;
  localparam int unsigned IdxBits    = $clog2(MaxRects);
  localparam int unsigned CntBits    = $clog2(MaxRects + 1);

  localparam logic [1:0] CfgAtlasWidth  = 2'd0;
  localparam logic [1:0] CfgAtlasHeight = 2'd1;
  localparam logic [1:0] CfgAddSpacing  = 2'd2;

  localparam logic OpPlace = 1'b0;
  localparam logic OpClear = 1'b1;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } box_t;

  // candidate spot broadcast down the chain
  typedef struct packed {
    logic   vld;
    logic   [IdxBits-1:0] anchor;
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } cand_t;

  function automatic logic boxes_overlap(box_t a, cand_t c);
    logic [CoordBits:0] ax2, ay2, cx2, cy2;
    begin
      ax2 = {1'b0, a.x} + {1'b0, a.w};
      ay2 = {1'b0, a.y} + {1'b0, a.h};
      cx2 = {1'b0, c.x} + {1'b0, c.w};
      cy2 = {1'b0, c.y} + {1'b0, c.h};
      boxes_overlap = ({1'b0, a.x} < cx2) && ({1'b0, c.x} < ax2) &&
                      ({1'b0, a.y} < cy2) && ({1'b0, c.y} < ay2);
    end
  endfunction

endpackage

FILE: hdl/arp_cell.sv
// one store slot: holds a box and checks the broadcast candidate against it
module arp_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [arp_pkg::IdxBits-1:0]       idx_i,
  input  logic                              clear_i,
  input  logic                              wr_i,
  input  arp_pkg::box_t                     wr_box_i,
  input  logic                              shift_i,
  input  arp_pkg::box_t                     prev_box_i,
  input  logic                              prev_vld_i,
  input  arp_pkg::cand_t                    cand_i,
  output arp_pkg::box_t                     box_o,
  output logic                              vld_o,
  output logic                              hit_o
);

  arp_pkg::box_t box_q;
  logic          vld_q;

  // the valid bit travels with its box around the ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (clear_i) begin
      vld_q <= 1'b0;
    end else if (wr_i) begin
      vld_q <= 1'b1;
    end else if (shift_i) begin
      vld_q <= prev_vld_i;
    end
  end

  // rotate ring: each slot hands its box to the neighbor while scanning
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      box_q <= wr_box_i;
    end else if (shift_i) begin
      box_q <= prev_box_i;
    end
  end

  assign box_o = box_q;
  assign vld_o = vld_q;
  assign hit_o = vld_q && cand_i.vld && (cand_i.anchor != idx_i) &&
                 arp_pkg::boxes_overlap(box_q, cand_i);

endmodule

FILE: hdl/atlas_rect_placer.sv
// channel | direction | handshake              | payload
// in      | input     | in_valid_i/in_stall_o  | op_i, rect_width_i, rect_height_i
// out     | output    | out_valid_o/out_stall_i | placed_o .. used_height_o
// cfg     | input     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// clear, refused place and first place into an empty store: the state goes from
// StIdle straight to StDone, and out_valid_o rises as StDone is left
// any other place rotates the whole ring of 64 cells once per pass, one spot
// per cycle checked by all cells at once; the below pass runs only when no
// right spot fits, and StDone then sets out_valid_o after the last pass
// a result waits in the output register; the next input transfer is taken in the
// cycle after the result transfer at the earliest
// reset empties the store and restores the register defaults
module atlas_rect_placer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_index_i,
  input  logic [arp_pkg::CoordBits-1:0]    cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic [arp_pkg::CoordBits-1:0]    rect_width_i,
  input  logic [arp_pkg::CoordBits-1:0]    rect_height_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             placed_o,
  output logic                             store_full_o,
  output logic [arp_pkg::CoordBits-1:0]    pos_x_o,
  output logic [arp_pkg::CoordBits-1:0]    pos_y_o,
  output logic [arp_pkg::CoordBits-1:0]    used_width_o,
  output logic [arp_pkg::CoordBits-1:0]    used_height_o
);

  localparam int unsigned N  = arp_pkg::MaxRects;
  localparam int unsigned CB = arp_pkg::CoordBits;
  localparam int unsigned IB = arp_pkg::IdxBits;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  // config registers
  logic [CB-1:0] atlas_w_q, atlas_h_q;
  logic          spacing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q <= CB'(1024);
      atlas_h_q <= CB'(1024);
      spacing_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        arp_pkg::CfgAtlasWidth:  atlas_w_q <= cfg_data_i;
        arp_pkg::CfgAtlasHeight: atlas_h_q <= cfg_data_i;
        arp_pkg::CfgAddSpacing:  spacing_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [1:0]                  state_q, state_d;
  logic [arp_pkg::CntBits-1:0] count_q;
  logic [IB-1:0]               step_q;   // rotations done in this pass
  logic                        pass_q;   // 0 right spots, 1 below spots
  logic [CB-1:0]               w_q, h_q;
  logic                        padx_q, pady_q;
  logic [CB-1:0]               maxw_q, maxh_q;
  logic                        out_vld_q, placed_q, full_q;
  logic [CB-1:0]               px_q, py_q;

  logic in_xfer, out_xfer;
  assign in_stall_o = (state_q != StIdle) || out_vld_q;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_vld_q && !out_stall_i;

  // padding for the incoming item
  logic [CB:0]   w_ext, h_ext;
  logic          padx_n, pady_n;
  logic [CB-1:0] w_pad_n, h_pad_n;
  assign w_ext   = {1'b0, rect_width_i} + (CB+1)'(1);
  assign h_ext   = {1'b0, rect_height_i} + (CB+1)'(1);
  assign padx_n  = spacing_q && (w_ext < {1'b0, atlas_w_q});
  assign pady_n  = spacing_q && (h_ext < {1'b0, atlas_h_q});
  assign w_pad_n = padx_n ? w_ext[CB-1:0] : rect_width_i;
  assign h_pad_n = pady_n ? h_ext[CB-1:0] : rect_height_i;

  // chain of cells
  arp_pkg::box_t  boxes [N];
  logic [N-1:0]   vlds;
  logic [N-1:0]   hits;
  arp_pkg::cand_t cand;
  logic           wr_en, shift_en, clr_en;
  arp_pkg::box_t  wr_box;
  logic [IB-1:0]  wr_idx;

  for (genvar g = 0; g < N; g++) begin : g_cell
    arp_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (IB'(g)),
      .clear_i    (clr_en),
      .wr_i       (wr_en && (wr_idx == IB'(g))),
      .wr_box_i   (wr_box),
      .shift_i    (shift_en),
      .prev_box_i (boxes[(g + 1) % N]),
      .prev_vld_i (vlds[(g + 1) % N]),
      .cand_i     (cand),
      .box_o      (boxes[g]),
      .vld_o      (vlds[g]),
      .hit_o      (hits[g])
    );
  end

  // the whole ring rotates left by one each scan cycle, so after step_q
  // shifts cell 0 holds slot step_q; a pass is a full turn and leaves the
  // ring back in slot order
  arp_pkg::box_t head;
  logic          head_vld;
  logic [CB:0]   cx_end, cy_end;
  logic          fits, take;
  assign head     = boxes[0];
  assign head_vld = vlds[0];

  always_comb begin
    cand.vld    = (state_q == StScan);
    cand.w      = w_q;
    cand.h      = h_q;
    cand.anchor = '0;   // anchor always sits in cell zero during scan
    if (!pass_q) begin
      cand.x = head.x + head.w;
      cand.y = head.y;
    end else begin
      cand.x = head.x;
      cand.y = head.y + head.h;
    end
  end

  // stored ends never pass the widest atlas, so the sums fit in CB+1 bits
  assign cx_end = ({1'b0, head.x} + (pass_q ? (CB+1)'(0) : {1'b0, head.w})) + {1'b0, w_q};
  assign cy_end = ({1'b0, head.y} + (pass_q ? {1'b0, head.h} : (CB+1)'(0))) + {1'b0, h_q};
  assign fits   = head_vld && (cx_end <= {1'b0, atlas_w_q}) &&
                  (cy_end <= {1'b0, atlas_h_q}) && (hits == '0);
  // first fitting spot only
  assign take   = (state_q == StScan) && !placed_q && fits;

  logic last_step;
  assign last_step = (step_q == IB'(N - 1));

  always_comb begin
    state_d  = state_q;
    shift_en = 1'b0;
    clr_en   = 1'b0;
    wr_en    = 1'b0;
    wr_idx   = count_q[IB-1:0];
    wr_box   = '{x: px_q, y: py_q, w: w_q, h: h_q};
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (op_i == arp_pkg::OpClear) begin
            clr_en  = 1'b1;
            state_d = StDone;
          end else if (count_q == arp_pkg::CntBits'(N) || count_q == '0) begin
            state_d = StDone;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        shift_en = 1'b1;
        if (last_step && (placed_q || take || pass_q)) state_d = StDone;
      end
      StDone: begin
        // ring is back in slot order here
        wr_en   = placed_q;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      step_q    <= '0;
      pass_q    <= 1'b0;
      maxw_q    <= '0;
      maxh_q    <= '0;
      out_vld_q <= 1'b0;
      placed_q  <= 1'b0;
      full_q    <= 1'b0;
      px_q      <= '0;
      py_q      <= '0;
      w_q       <= '0;
      h_q       <= '0;
      padx_q    <= 1'b0;
      pady_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StDone) begin
        out_vld_q <= 1'b1;
        if (placed_q) count_q <= count_q + 1'b1;
      end else if (out_xfer) begin
        out_vld_q <= 1'b0;
      end
      if (state_q == StIdle && in_xfer) begin
        step_q     <= '0;
        pass_q     <= 1'b0;
        placed_q   <= 1'b0;
        full_q     <= 1'b0;
        px_q       <= '0;
        py_q       <= '0;
        w_q        <= w_pad_n;
        h_q        <= h_pad_n;
        padx_q     <= padx_n;
        pady_q     <= pady_n;
        if (op_i == arp_pkg::OpClear) begin
          count_q <= '0;
          maxw_q  <= '0;
          maxh_q  <= '0;
        end else if (count_q == arp_pkg::CntBits'(N)) begin
          full_q <= 1'b1;
        end else if (count_q == '0) begin
          // first rectangle lands at the origin unchecked
          placed_q <= 1'b1;
          maxw_q   <= w_pad_n - CB'(padx_n);
          maxh_q   <= h_pad_n - CB'(pady_n);
        end
      end
      if (state_q == StScan) begin
        step_q <= step_q + 1'b1;
        if (last_step) pass_q <= 1'b1;
        if (take) begin
          placed_q <= 1'b1;
          px_q     <= cand.x;
          py_q     <= cand.y;
          if (cx_end > {1'b0, maxw_q}) maxw_q <= cx_end[CB-1:0] - CB'(padx_q);
          if (cy_end > {1'b0, maxh_q}) maxh_q <= cy_end[CB-1:0] - CB'(pady_q);
        end
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign placed_o      = placed_q;
  assign store_full_o  = full_q;
  assign pos_x_o       = px_q;
  assign pos_y_o       = py_q;
  assign used_width_o  = maxw_q;
  assign used_height_o = maxh_q;

`ifndef SYNTH
  a_no_in_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("input taken while busy");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= arp_pkg::CntBits'(N)) else $error("count overflow");
  a_placed_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(placed_q && full_q)) else $error("placed and full");
  a_out_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (state_q == StIdle)) else $error("result while busy");
`endif

endmodule
